FILE: hdl/wpdh_pkg.sv
// ----------------------------------------------------------------------------
// Weighted pair distance histogram package
// Shared types and constants for the histogram engine.
// ----------------------------------------------------------------------------
package wpdh_pkg;

  localparam int MaxPoints = 1024;
  localparam int NumBins   = 1024;
  localparam int PtIdxW    = $clog2(MaxPoints);
  localparam int CntW      = PtIdxW + 1;
  localparam int BinIdxW   = $clog2(NumBins);
  localparam int CoordW    = 24;
  localparam int WeightW   = 16;
  localparam int ValW      = 48;
  localparam int PointW    = 3 * CoordW + WeightW;

  localparam logic [1:0] ReqLoad    = 2'd0;
  localparam logic [1:0] ReqCompute = 2'd1;
  localparam logic [1:0] ReqRead    = 2'd2;
  localparam logic [1:0] ReqClear   = 2'd3;

  localparam logic [1:0] CfgSelfMode  = 2'd0;
  localparam logic [1:0] CfgBinWidth  = 2'd1;
  localparam logic [1:0] CfgBinsInUse = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH,
    ST_WAIT,
    ST_DIFF,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_RDBIN,
    ST_WRBIN,
    ST_READ,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/wpdh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wpdh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/wpdh_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root and divider
// One shared shift-subtract unit: a 32-step square root of a 64-bit value,
// then a 32-step restoring division of the root by the bin width.
// ----------------------------------------------------------------------------
module wpdh_sqrt
  import wpdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic        phase;   // 0 square root, 1 division
  logic [5:0]  step;
  logic [63:0] rem;
  logic [65:0] acc;
  logic [31:0] root;
  logic [31:0] q;
  logic [32:0] drem;

  logic [65:0] trial;
  logic [65:0] shifted;
  logic [32:0] dshift;

  assign shifted = {acc[63:0], rem[63:62]};
  assign trial   = {32'd0, root, 2'b01};
  assign dshift  = {drem[31:0], q[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        step  <= 6'd0;
        rem   <= radicand;
        acc   <= '0;
        root  <= '0;
      end else if (busy) begin
        step <= step + 6'd1;
        if (!phase) begin
          rem <= {rem[61:0], 2'b00};
          if (shifted >= trial) begin
            acc  <= shifted - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            acc  <= shifted;
            root <= {root[30:0], 1'b0};
          end
          if (step == 6'd31) begin
            phase <= 1'b1;
            step  <= 6'd0;
            q     <= (shifted >= trial) ? {root[30:0], 1'b1} : {root[30:0], 1'b0};
            drem  <= '0;
          end
        end else begin
          if (dshift >= {17'd0, divisor}) begin
            drem <= dshift - {17'd0, divisor};
            q    <= {q[30:0], 1'b1};
          end else begin
            drem <= dshift;
            q    <= {q[30:0], 1'b0};
          end
          if (step == 6'd31) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign quotient = q;

endmodule

FILE: hdl/weighted_pair_distance_histogram.sv
// ----------------------------------------------------------------------------
// Weighted pair distance histogram
// Loads weighted 3-D points into two sets and bins weighted pair distances.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  request   in         valid / stall    req_type .. read_index
//  result    out        out_valid/stall  bin_index, bin_value, overflow, done_res
//  config    in         cfg_we           cfg_index, cfg_data
//
// A load is taken every cycle while the block is idle. A read captures its bin
// in ST_READ, offers its result beat from ST_OUT and then returns to ST_IDLE.
// A compute clears the histogram, then walks the pairs: each pair is measured
// (ST_FETCH to ST_DIV) and, if its bin is in range, added in ST_RDBIN/ST_WRBIN;
// a self term goes straight to bin 0. The result beat follows the last pair.
// Clear all also sweeps the histogram. After reset a clearing pass runs before
// the first request. A stalled result holds; no request is taken until it leaves.
// ----------------------------------------------------------------------------
module weighted_pair_distance_histogram
  import wpdh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 stall,
  input  logic [1:0]           req_type,
  input  logic                 to_set_b,
  input  logic signed [23:0]   pos_x,
  input  logic signed [23:0]   pos_y,
  input  logic signed [23:0]   pos_z,
  input  logic [15:0]          weight,
  input  logic [9:0]           read_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [9:0]           bin_index,
  output logic [47:0]          bin_value,
  output logic                 overflow,
  output logic                 done_res,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic        self_mode;
  logic [15:0] bin_width;
  logic [10:0] bins_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_mode   <= 1'b0;
      bin_width   <= 16'd256;
      bins_in_use <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgSelfMode:  self_mode   <= cfg_data[0];
        CfgBinWidth:  bin_width   <= cfg_data;
        CfgBinsInUse: bins_in_use <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Absolute difference of two signed coordinates.
  function automatic logic [24:0] axis_dist(logic [23:0] a, logic [23:0] b);
    logic signed [24:0] sa, sb;
    sa = $signed({a[23], a});
    sb = $signed({b[23], b});
    return (sa >= sb) ? $unsigned(sa - sb) : $unsigned(sb - sa);
  endfunction

  state_t state, state_next;

  logic [CntW-1:0]    count_a, count_b;
  logic [PtIdxW-1:0]  idx_i, idx_j;
  logic [BinIdxW-1:0] clr_idx;
  logic               ovf;
  logic               self_term;  // current pass adds w*w of point i
  logic               clr_then_compute;
  logic [BinIdxW-1:0] bin_sel;
  logic [47:0]        add_val;
  logic [24:0]        dx, dy, dz;
  logic [63:0]        d2;
  logic [1:0]         sq_step;
  logic [BinIdxW-1:0] rd_idx;
  logic               last_pair;
  logic [CntW-1:0]    j_nxt;

  // Point memories
  logic              a_we, b_we;
  logic [PointW-1:0] a_rd, b_rd, pt_wdata;
  logic [PtIdxW-1:0] b_raddr;

  assign pt_wdata = {pos_x, pos_y, pos_z, weight};

  wpdh_ram #(.Width(PointW), .Depth(MaxPoints)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(count_a[PtIdxW-1:0]), .wdata(pt_wdata),
    .raddr(idx_i), .rdata(a_rd)
  );

  wpdh_ram #(.Width(PointW), .Depth(MaxPoints)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(count_b[PtIdxW-1:0]), .wdata(pt_wdata),
    .raddr(b_raddr), .rdata(b_rd)
  );

  // In self mode the partner point is read from a second copy of set A.
  logic [PointW-1:0] a2_rd;
  wpdh_ram #(.Width(PointW), .Depth(MaxPoints)) u_ram_a2 (
    .clk(clk), .we(a_we), .waddr(count_a[PtIdxW-1:0]), .wdata(pt_wdata),
    .raddr(idx_j), .rdata(a2_rd)
  );
  assign b_raddr = idx_j;

  // Histogram memory
  logic              h_we;
  logic [BinIdxW-1:0] h_waddr, h_raddr;
  logic [ValW-1:0]   h_wdata, h_rd;

  wpdh_ram #(.Width(ValW), .Depth(NumBins)) u_ram_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rd)
  );

  // Shared square root and divider
  logic        sq_start, sq_done;
  logic [31:0] quot;
  logic [15:0] width_eff;
  assign width_eff = (bin_width == 16'd0) ? 16'd1 : bin_width;

  wpdh_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(d2),
    .divisor(width_eff), .done(sq_done), .quotient(quot)
  );

  // Shared multiplier for squares and weight products
  logic [24:0] mul_a, mul_b;
  logic [49:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [PointW-1:0] p1, p2;
  assign p1 = a_rd;
  assign p2 = self_mode ? a2_rd : b_rd;

  logic [10:0] limit;
  assign limit = (bins_in_use == 11'd0) ? 11'd1 :
                 (bins_in_use > 11'(NumBins)) ? 11'(NumBins) : bins_in_use;

  logic [CntW-1:0] n_i, n_j;
  logic [CntW-1:0] i_ext, j_ext;
  assign i_ext = {1'b0, idx_i};
  assign j_ext = {1'b0, idx_j};
  assign n_j   = self_mode ? count_a : count_b;
  assign n_i   = count_a;
  assign j_nxt = j_ext + CntW'(1);

  logic [ValW:0] h_sum;
  assign h_sum = {1'b0, h_rd} + {1'b0, add_val};

  always_comb begin
    state_next = state;
    stall      = 1'b1;
    a_we       = 1'b0;
    b_we       = 1'b0;
    h_we       = 1'b0;
    h_waddr    = clr_idx;
    h_wdata    = '0;
    h_raddr    = bin_sel;
    sq_start   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        stall   = 1'b0;
        // Start the bin read with the request so the data is ready in ST_READ.
        h_raddr = read_index;
        if (valid) begin
          case (req_type)
            ReqLoad: begin
              a_we = !to_set_b && (count_a < CntW'(MaxPoints));
              b_we = to_set_b && (count_b < CntW'(MaxPoints));
            end
            ReqCompute: state_next = ST_CLEAR;
            ReqRead:    state_next = ST_READ;
            default:    state_next = ST_CLEAR;
          endcase
        end
      end
      ST_CLEAR: begin
        h_we = 1'b1;
        if (clr_idx == BinIdxW'(NumBins - 1)) begin
          if (!clr_then_compute) begin
            state_next = ST_IDLE;
          end else if (count_a == '0 || (!self_mode && count_b == '0)) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_next = last_pair ? ST_OUT : ST_WAIT;
      ST_WAIT:  state_next = self_term ? ST_RDBIN : ST_DIFF;
      ST_DIFF:  state_next = ST_SQUARE;
      ST_SQUARE: begin
        case (sq_step)
          2'd0: begin mul_a = dx; mul_b = dx; end
          2'd1: begin mul_a = dy; mul_b = dy; end
          2'd2: begin mul_a = dz; mul_b = dz; end
          default: ;
        endcase
        // The last square lands in d2 before the root starts.
        if (sq_step == 2'd3) begin
          sq_start   = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: if (sq_done) state_next = ST_DIV;
      ST_DIV: begin
        mul_a = {9'd0, p1[15:0]};
        mul_b = {9'd0, p2[15:0]};
        state_next = (quot >= {21'd0, limit}) ? ST_FETCH : ST_RDBIN;
      end
      ST_RDBIN: begin
        if (self_term) begin
          h_raddr = '0;
          mul_a = {9'd0, p1[15:0]};
          mul_b = {9'd0, p1[15:0]};
        end
        state_next = ST_WRBIN;
      end
      ST_WRBIN: begin
        h_we    = 1'b1;
        h_waddr = bin_sel;
        h_wdata = h_sum[ValW] ? {ValW{1'b1}} : h_sum[ValW-1:0];
        state_next = ST_FETCH;
      end
      ST_READ: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_then_compute <= 1'b0;
      clr_idx          <= '0;
      count_a          <= '0;
      count_b          <= '0;
      ovf              <= 1'b0;
      out_valid        <= 1'b0;
      last_pair        <= 1'b0;
    end else begin
      state <= state_next;
      if (a_we) count_a <= count_a + CntW'(1);
      if (b_we) count_b <= count_b + CntW'(1);
      case (state)
        ST_IDLE: begin
          clr_idx <= '0;
          if (valid) begin
            clr_then_compute <= (req_type == ReqCompute);
            rd_idx           <= read_index;
            if (req_type == ReqClear) begin
              count_a <= '0;
              count_b <= '0;
              ovf     <= 1'b0;
            end
            idx_i     <= '0;
            idx_j     <= '0;
            self_term <= self_mode;
            last_pair <= 1'b0;
          end
        end
        ST_CLEAR: clr_idx <= clr_idx + BinIdxW'(1);
        ST_FETCH: sq_step <= '0;
        ST_DIFF: begin
          dx <= axis_dist(p1[87:64], p2[87:64]);
          dy <= axis_dist(p1[63:40], p2[63:40]);
          dz <= axis_dist(p1[39:16], p2[39:16]);
          d2 <= '0;
        end
        ST_SQUARE: begin
          d2      <= d2 + {14'd0, mul_p};
          sq_step <= sq_step + 2'd1;
        end
        ST_DIV: begin
          if (quot >= {21'd0, limit}) ovf <= 1'b1;
          bin_sel <= quot[BinIdxW-1:0];
          add_val <= {mul_p[46:0], 1'b0};
        end
        ST_RDBIN: if (self_term) begin
          bin_sel <= '0;
          add_val <= mul_p[47:0];
        end
        default: ;
      endcase
      // Advance the pair walk when a pair or self term finishes.
      if ((state == ST_DIV && quot >= {21'd0, limit}) || state == ST_WRBIN) begin
        if (self_term) begin
          self_term <= 1'b0;
          idx_j     <= idx_i + PtIdxW'(1);
          if (i_ext + CntW'(1) >= n_i) last_pair <= 1'b1;
        end else if (j_nxt < n_j) begin
          idx_j <= j_nxt[PtIdxW-1:0];
        end else begin
          idx_i <= idx_i + PtIdxW'(1);
          if (self_mode) begin
            self_term <= 1'b1;
            idx_j     <= idx_i + PtIdxW'(1);
          end else begin
            idx_j <= '0;
          end
          if (i_ext + CntW'(1) >= n_i) last_pair <= 1'b1;
        end
      end
      if (state == ST_CLEAR && clr_idx == BinIdxW'(NumBins - 1) && state_next == ST_OUT) begin
        out_valid <= 1'b1;
        bin_index <= '0;
        bin_value <= '0;
        done_res  <= 1'b1;
      end
      if (state == ST_FETCH && last_pair) begin
        out_valid <= 1'b1;
        bin_index <= '0;
        bin_value <= '0;
        done_res  <= 1'b1;
      end
      if (state == ST_READ) begin
        out_valid <= 1'b1;
        bin_index <= rd_idx;
        bin_value <= h_rd;
        done_res  <= 1'b0;
      end
      if (state == ST_OUT && !out_stall) out_valid <= 1'b0;
    end
  end

  assign overflow = ovf;

endmodule

FILE: bench/tb_weighted_pair_distance_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted pair distance histogram testbench
// Drives load, compute, read and clear requests with random gaps, predicts
// every result beat in a behavioral histogram model and checks the beats in
// order. Register settings are changed between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_weighted_pair_distance_histogram;
  import wpdh_pkg::*;

  localparam int QuietCycles = 1300;
  localparam longint unsigned BinTop = 64'h0000_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {EntryReq, EntryCfg, EntryDrain} entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic [1:0]  req;
    logic        tob;
    logic [23:0] x, y, z;
    logic [15:0] w;
    logic [9:0]  ridx;
    logic [1:0]  cidx;
    logic [15:0] cdata;
    int          gap;
  } stim_t;

  typedef struct {
    logic [9:0]  idx;
    logic [47:0] val;
    logic        ovf;
    logic        done;
  } bin_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic stall;
  logic [1:0] req_type = '0;
  logic to_set_b = 1'b0;
  logic [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] weight = '0;
  logic [9:0] read_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] bin_index;
  logic [47:0] bin_value;
  logic overflow;
  logic done_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  weighted_pair_distance_histogram dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Histogram model state.
  logic        mdl_self;
  logic [15:0] mdl_width;
  logic [10:0] mdl_bins;
  logic [23:0] pa_x[MaxPoints], pa_y[MaxPoints], pa_z[MaxPoints];
  logic [15:0] pa_w[MaxPoints];
  logic [23:0] pb_x[MaxPoints], pb_y[MaxPoints], pb_z[MaxPoints];
  logic [15:0] pb_w[MaxPoints];
  int          na_pts, nb_pts;
  longint unsigned hist[NumBins];
  logic        mdl_ovf;

  stim_t     pending_q[$];
  bin_beat_t expected_bins[$];
  int        n_fail = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned axis_sq(logic [23:0] a, logic [23:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  function automatic void bin_accumulate(int b, longint unsigned v);
    longint unsigned h;
    h = hist[b] + v;
    hist[b] = (h > BinTop) ? BinTop : h;
  endfunction

  function automatic void add_pair(logic [23:0] x1, y1, z1, logic [15:0] w1,
                                   logic [23:0] x2, y2, z2, logic [15:0] w2,
                                   longint unsigned width, int lim);
    longint unsigned d2, b;
    d2 = axis_sq(x1, x2) + axis_sq(y1, y2) + axis_sq(z1, z2);
    b = int_sqrt(d2) / width;
    if (b >= lim) mdl_ovf = 1'b1;
    else bin_accumulate(int'(b), 64'd2 * w1 * w2);
  endfunction

  function automatic void clear_model();
    foreach (hist[i]) hist[i] = 0;
    na_pts = 0;
    nb_pts = 0;
    mdl_ovf = 1'b0;
  endfunction

  function automatic void build_histogram();
    longint unsigned width;
    int lim;
    width = (mdl_width == 0) ? 1 : mdl_width;
    lim = (mdl_bins < 1) ? 1 : (mdl_bins > NumBins) ? NumBins : mdl_bins;
    foreach (hist[i]) hist[i] = 0;
    if (mdl_self) begin
      for (int i = 0; i < na_pts; i++) begin
        bin_accumulate(0, longint'(pa_w[i]) * pa_w[i]);
        for (int j = i + 1; j < na_pts; j++)
          add_pair(pa_x[i], pa_y[i], pa_z[i], pa_w[i],
                   pa_x[j], pa_y[j], pa_z[j], pa_w[j], width, lim);
      end
    end else begin
      for (int i = 0; i < na_pts; i++)
        for (int j = 0; j < nb_pts; j++)
          add_pair(pa_x[i], pa_y[i], pa_z[i], pa_w[i],
                   pb_x[j], pb_y[j], pb_z[j], pb_w[j], width, lim);
    end
  endfunction

  // Applies one accepted request to the model and queues its result beat, if any.
  function automatic void predict_request(stim_t s);
    bin_beat_t r;
    case (s.req)
      ReqLoad: begin
        if (s.tob && nb_pts < MaxPoints) begin
          pb_x[nb_pts] = s.x; pb_y[nb_pts] = s.y; pb_z[nb_pts] = s.z;
          pb_w[nb_pts] = s.w;
          nb_pts++;
        end else if (!s.tob && na_pts < MaxPoints) begin
          pa_x[na_pts] = s.x; pa_y[na_pts] = s.y; pa_z[na_pts] = s.z;
          pa_w[na_pts] = s.w;
          na_pts++;
        end
      end
      ReqCompute: begin
        build_histogram();
        r = '{idx: '0, val: '0, ovf: mdl_ovf, done: 1'b1};
        expected_bins.insert(expected_bins.size(), r);
      end
      ReqRead: begin
        r = '{idx: s.ridx, val: hist[s.ridx][47:0], ovf: mdl_ovf, done: 1'b0};
        expected_bins.insert(expected_bins.size(), r);
      end
      default: clear_model();
    endcase
  endfunction

  // ---------------- driver ----------------
  stim_t stg;
  logic  staged = 1'b0;
  int    wait_cnt = 0;
  int    quiet = 0;
  logic  v_next, we_next;

  always @(posedge clk) begin
    v_next = valid;
    we_next = 1'b0;
    if (rst) begin
      v_next = 1'b0;
      staged = 1'b0;
      quiet = 0;
      mdl_self = 1'b0;
      mdl_width = 16'd256;
      mdl_bins = 11'd1024;
      clear_model();
    end else begin
      if ((valid && !stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (valid && !stall) begin
        predict_request(stg);
        v_next = 1'b0;
      end
      if (!v_next && !staged && pending_q.size() > 0) begin
        stg = pending_q.pop_front();
        staged = 1'b1;
        wait_cnt = stg.gap;
      end
      if (!v_next && staged) begin
        if (wait_cnt > 0) begin
          wait_cnt--;
        end else if (stg.kind == EntryReq) begin
          req_type <= stg.req;
          to_set_b <= stg.tob;
          pos_x <= stg.x;
          pos_y <= stg.y;
          pos_z <= stg.z;
          weight <= stg.w;
          read_index <= stg.ridx;
          v_next = 1'b1;
          staged = 1'b0;
        end else if (expected_bins.size() == 0 &&
                     (stg.kind == EntryDrain || quiet >= QuietCycles)) begin
          if (stg.kind == EntryCfg) begin
            we_next = 1'b1;
            cfg_index <= stg.cidx;
            cfg_data <= stg.cdata;
            case (stg.cidx)
              CfgSelfMode: mdl_self = stg.cdata[0];
              CfgBinWidth: mdl_width = stg.cdata;
              default:     mdl_bins = stg.cdata[10:0];
            endcase
          end
          staged = 1'b0;
        end
      end
    end
    valid <= v_next;
    cfg_we <= we_next;
  end

  // ---------------- monitor ----------------
  int   stall_cnt = 0;
  int   hold_cnt = 0;
  int   n_beats = 0;
  logic rx_burst = 1'b0;
  bin_beat_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bins.size() == 0) begin
          $error("result beat with nothing expected");
          n_fail++;
        end else begin
          want = expected_bins.pop_front();
          if (bin_index !== want.idx) begin
            $error("bin_index expected %0d actual %0d", want.idx, bin_index);
            n_fail++;
          end
          if (bin_value !== want.val) begin
            $error("bin_value expected %0h actual %0h", want.val, bin_value);
            n_fail++;
          end
          if (overflow !== want.ovf) begin
            $error("overflow expected %0b actual %0b", want.ovf, overflow);
            n_fail++;
          end
          if (done_res !== want.done) begin
            $error("done_res expected %0b actual %0b", want.done, done_res);
            n_fail++;
          end
        end
        n_beats++;
        // Long hold-offs let the request side back up behind a parked result.
        if (n_beats == 20 || n_beats == 250) hold_cnt = 500;
        if ($urandom_range(0, 9) == 0) rx_burst = !rx_burst;
        stall_cnt = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- stimulus ----------------
  int   n_items = 0;
  logic tx_burst = 1'b0;

  function automatic int next_gap();
    return tx_burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return 24'($urandom());
    return 24'($urandom_range(0, 4000)) - 24'd2000;
  endfunction

  function automatic stim_t noise_entry();
    stim_t s;
    s.kind = EntryReq;
    s.req = 2'($urandom());
    s.tob = 1'($urandom());
    s.x = 24'($urandom());
    s.y = 24'($urandom());
    s.z = 24'($urandom());
    s.w = 16'($urandom());
    s.ridx = 10'($urandom());
    s.cidx = '0;
    s.cdata = '0;
    s.gap = next_gap();
    return s;
  endfunction

  function automatic void add_load(logic tob, logic [23:0] x, y, z, logic [15:0] w);
    stim_t s;
    s = noise_entry();
    s.req = ReqLoad;
    s.tob = tob;
    s.x = x; s.y = y; s.z = z; s.w = w;
    pending_q.insert(pending_q.size(), s);
    n_items++;
  endfunction

  function automatic void add_req(logic [1:0] req, logic [9:0] ridx);
    stim_t s;
    s = noise_entry();
    s.req = req;
    s.ridx = ridx;
    pending_q.insert(pending_q.size(), s);
    n_items++;
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [15:0] data);
    stim_t s;
    s = noise_entry();
    s.kind = EntryCfg;
    s.cidx = idx;
    s.cdata = data;
    pending_q.insert(pending_q.size(), s);
  endfunction

  function automatic void add_drain();
    stim_t s;
    s = noise_entry();
    s.kind = EntryDrain;
    pending_q.insert(pending_q.size(), s);
  endfunction

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd65535;
      3: return 16'd16;
      default: return 16'($urandom_range(64, 1024));
    endcase
  endfunction

  function automatic logic [15:0] pick_bins();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd1024;
      3: return 16'd2047;
      default: return 16'($urandom_range(2, 1024));
    endcase
  endfunction

  int fill_a, fill_b;

  initial begin
    // Directed: extreme coordinates and weights, all request kinds.
    add_req(ReqRead, 10'd0);
    add_req(ReqRead, 10'd1023);
    add_load(1'b0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 16'hffff);
    add_load(1'b0, 24'h800000, 24'h800000, 24'h800000, 16'hffff);
    add_load(1'b0, 24'h000000, 24'h000000, 24'h000000, 16'h0000);
    add_load(1'b0, 24'h000100, 24'h000000, 24'h000000, 16'h0100);
    add_load(1'b1, 24'h000000, 24'h000000, 24'h000000, 16'hffff);
    add_load(1'b1, 24'h000200, 24'h000000, 24'h000000, 16'h0001);
    add_req(ReqCompute, 10'd0);
    add_req(ReqRead, 10'd0);
    add_req(ReqRead, 10'd1);
    add_req(ReqRead, 10'd2);
    add_cfg(CfgSelfMode, 16'd1);
    add_cfg(CfgBinWidth, 16'd0);
    add_cfg(CfgBinsInUse, 16'd0);
    add_req(ReqCompute, 10'd0);
    add_req(ReqRead, 10'd0);
    add_cfg(CfgBinWidth, 16'd65535);
    add_cfg(CfgBinsInUse, 16'd2047);
    add_req(ReqCompute, 10'd0);
    add_req(ReqRead, 10'd0);
    add_req(ReqRead, 10'd1);
    add_req(ReqClear, 10'd0);
    add_req(ReqRead, 10'd0);
    add_req(ReqCompute, 10'd0);
    add_req(ReqRead, 10'd0);
    add_cfg(CfgSelfMode, 16'd0);
    add_cfg(CfgBinWidth, 16'd256);
    add_cfg(CfgBinsInUse, 16'd1024);

    // A full set B: the load past the last slot must be ignored.
    tx_burst = 1'b1;
    add_load(1'b0, 24'd0, 24'd0, 24'd0, 16'h0100);
    for (int i = 0; i <= MaxPoints; i++)
      add_load(1'b1, 24'($urandom_range(0, 60000)), 24'd0, 24'd0,
               (i == MaxPoints) ? 16'hffff : 16'($urandom_range(1, 255)));
    tx_burst = 1'b0;
    add_req(ReqCompute, 10'd0);
    for (int i = 0; i < 4; i++) add_req(ReqRead, 10'($urandom_range(0, 240)));
    add_drain();
    add_req(ReqClear, 10'd0);

    // Random phases: load a few points, build, read back.
    fill_a = 0;
    fill_b = 0;
    while (n_items < 1850) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        add_cfg(CfgSelfMode, 16'($urandom()));
        add_cfg(CfgBinWidth, pick_width());
        add_cfg(CfgBinsInUse, pick_bins());
      end
      if (fill_a > 8 || fill_b > 8 || $urandom_range(0, 3) == 0) begin
        add_req(ReqClear, 10'($urandom()));
        fill_a = 0;
        fill_b = 0;
      end
      repeat ($urandom_range(0, 4)) begin
        add_load(1'b0, rand_coord(), rand_coord(), rand_coord(), 16'($urandom()));
        fill_a++;
      end
      repeat ($urandom_range(0, 4)) begin
        add_load(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom()));
        fill_b++;
      end
      if ($urandom_range(0, 5) == 0) add_req(ReqRead, 10'($urandom()));
      if ($urandom_range(0, 4) != 0) add_req(ReqCompute, 10'($urandom()));
      repeat ($urandom_range(2, 10))
        add_req(ReqRead, ($urandom_range(0, 2) == 0) ? 10'($urandom())
                                                      : 10'($urandom_range(0, 40)));
      if ($urandom_range(0, 7) == 0) add_drain();
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || staged || valid) @(posedge clk);
    while (expected_bins.size() > 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/wpdh_pkg.sv
hdl/wpdh_ram.sv
hdl/wpdh_sqrt.sv
hdl/weighted_pair_distance_histogram.sv
bench/tb_weighted_pair_distance_histogram.sv
